/* design/hsfd_pkg.sv */
package hsfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scaling constants: span over full scale, offset in hundredths
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;

  typedef enum logic [2:0] {
    POS_TEMP_HI  = 3'd0,
    POS_TEMP_LO  = 3'd1,
    POS_TEMP_CRC = 3'd2,
    POS_HUM_HI   = 3'd3,
    POS_HUM_LO   = 3'd4,
    POS_HUM_CRC  = 3'd5
  } pos_t;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_TEMP_BAD = 2'd1,
    ST_HUM_BAD  = 2'd2
  } status_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/hsfd_if.sv */
interface hsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_begin;

  modport source (output valid, output rx_byte, output frame_begin, input ready);
  modport sink (input valid, input rx_byte, input frame_begin, output ready);
endinterface

interface hsfd_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  frame_status;
  logic        [15:0] temp_word;
  logic        [15:0] hum_word;
  logic signed [14:0] temp_centi;
  logic        [13:0] hum_centi;

  modport source (output valid, output frame_status, output temp_word, output hum_word,
                  output temp_centi, output hum_centi, input ready);
  modport sink (input valid, input frame_status, input temp_word, input hum_word,
                input temp_centi, input hum_centi, output ready);
endinterface

/* design/humidity_sensor_frame_decoder.sv */
// Decoder for the six-byte reply of a temperature/humidity sensor.
// in_ch carries one reply byte per beat (rx_byte) with frame_begin set on the
// first byte of a reply; frame_begin realigns the decoder and drops any
// partial frame. Byte order: temperature word (MSB first), its CRC-8,
// humidity word (MSB first), its CRC-8. Both CRCs use polynomial 0x31, seed 0xFF.
// out_ch carries one beat per complete reply: the status (good, temperature
// CRC bad, humidity CRC bad), the last good raw words and both values scaled
// to hundredths. A bad frame leaves the previous good words in place.
// Result path: the sixth byte is taken into the input register, and the result
// register loads from there when it is free; out_ch.valid comes straight from
// the result register.
// Throughput: one byte per cycle unless stalled as below; the CRC, the frame
// bookkeeping and the constant-multiply scaling all sit in the single stage
// between the input register and the result register.
// Stall: while a result beat waits on out_ch, bytes that produce no result
// keep flowing; in_ch.ready drops only when the input register holds a
// sixth byte and the result register is still occupied.
// Reset (synchronous, rst_n low): both registers empty, position back to the
// first byte, good words cleared to zero.
module humidity_sensor_frame_decoder (
  input  logic             clk,
  input  logic             rst_n,
  hsfd_in_if.sink          in_ch,
  hsfd_out_if.source       out_ch
);
  import hsfd_pkg::*;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_begin_r;

  // Frame state
  pos_t        pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        temp_ok_r, temp_ok_nxt;
  logic [15:0] pend_temp_r, pend_temp_nxt;
  logic [15:0] pend_hum_r, pend_hum_nxt;
  logic [15:0] good_temp_r, good_temp_nxt;
  logic [15:0] good_hum_r, good_hum_nxt;

  // Result register
  logic               out_valid_r;
  status_t            out_status_r;
  logic        [15:0] out_temp_word_r;
  logic        [15:0] out_hum_word_r;
  logic signed [14:0] out_temp_centi_r;
  logic        [13:0] out_hum_centi_r;

  pos_t    eff_pos;
  logic    s1_emits;
  logic    out_free;
  logic    s1_fire;
  logic    in_fire;
  status_t status_nxt;

  logic [30:0] temp_prod;
  logic [31:0] temp_sum;
  logic [14:0] temp_q;
  logic [29:0] hum_prod;
  logic [30:0] hum_sum;

  // frame_begin or an impossible position restarts at the first byte
  assign eff_pos  = (s1_begin_r || (pos_r > POS_HUM_CRC)) ? POS_TEMP_HI : pos_r;
  assign s1_emits = s1_valid_r && (eff_pos == POS_HUM_CRC);
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && (!s1_emits || out_free);
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || s1_fire;

  // Next position
  always_comb begin
    pos_nxt = pos_r;
    if (s1_fire) begin
      unique case (eff_pos)
        POS_TEMP_HI:  pos_nxt = POS_TEMP_LO;
        POS_TEMP_LO:  pos_nxt = POS_TEMP_CRC;
        POS_TEMP_CRC: pos_nxt = POS_HUM_HI;
        POS_HUM_HI:   pos_nxt = POS_HUM_LO;
        POS_HUM_LO:   pos_nxt = POS_HUM_CRC;
        POS_HUM_CRC:  pos_nxt = POS_TEMP_HI;
        default:      pos_nxt = POS_TEMP_HI;
      endcase
    end
  end

  // Datapath per position
  always_comb begin
    crc_nxt       = crc_r;
    temp_ok_nxt   = temp_ok_r;
    pend_temp_nxt = pend_temp_r;
    pend_hum_nxt  = pend_hum_r;
    good_temp_nxt = good_temp_r;
    good_hum_nxt  = good_hum_r;
    status_nxt    = ST_GOOD;
    if (s1_fire) begin
      unique case (eff_pos)
        POS_TEMP_HI: begin
          pend_temp_nxt = {s1_byte_r, 8'h00};
          crc_nxt       = crc8_byte(CRC_INIT, s1_byte_r);
        end
        POS_TEMP_LO: begin
          pend_temp_nxt = {pend_temp_r[15:8], s1_byte_r};
          crc_nxt       = crc8_byte(crc_r, s1_byte_r);
        end
        POS_TEMP_CRC: begin
          temp_ok_nxt = (crc_r == s1_byte_r);
        end
        POS_HUM_HI: begin
          pend_hum_nxt = {s1_byte_r, 8'h00};
          crc_nxt      = crc8_byte(CRC_INIT, s1_byte_r);
        end
        POS_HUM_LO: begin
          pend_hum_nxt = {pend_hum_r[15:8], s1_byte_r};
          crc_nxt      = crc8_byte(crc_r, s1_byte_r);
        end
        POS_HUM_CRC: begin
          crc_nxt = CRC_INIT;
          if (!temp_ok_r) begin
            status_nxt = ST_TEMP_BAD;
          end else if (crc_r != s1_byte_r) begin
            status_nxt = ST_HUM_BAD;
          end else begin
            good_temp_nxt = pend_temp_r;
            good_hum_nxt  = pend_hum_r;
          end
        end
        default: begin
          crc_nxt = crc_r;
        end
      endcase
    end
  end

  // Scale to hundredths; divide by 65535 as (x + (x >> 16) + 1) >> 16
  assign temp_prod = 31'(good_temp_nxt) * 31'(TEMP_SPAN);
  assign temp_sum  = 32'(temp_prod) + 32'(temp_prod >> 16) + 32'd1;
  assign temp_q    = temp_sum[30:16];
  assign hum_prod  = 30'(good_hum_nxt) * 30'(HUM_SPAN);
  assign hum_sum   = 31'(hum_prod) + 31'(hum_prod >> 16) + 31'd1;

  // Input register: take a beat whenever the stage frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_fire) begin
      s1_byte_r  <= in_ch.rx_byte;
      s1_begin_r <= in_ch.frame_begin;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_TEMP_HI;
      crc_r       <= CRC_INIT;
      temp_ok_r   <= 1'b0;
      good_temp_r <= 16'd0;
      good_hum_r  <= 16'd0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_ok_r   <= temp_ok_nxt;
      good_temp_r <= good_temp_nxt;
      good_hum_r  <= good_hum_nxt;
    end
    pend_temp_r <= pend_temp_nxt;
    pend_hum_r  <= pend_hum_nxt;
  end

  // Result register: load on a sixth byte, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_emits) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_fire && s1_emits) begin
      out_status_r     <= status_nxt;
      out_temp_word_r  <= good_temp_nxt;
      out_hum_word_r   <= good_hum_nxt;
      out_temp_centi_r <= $signed(temp_q - TEMP_OFFSET);
      out_hum_centi_r  <= hum_sum[29:16];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_status = out_status_r;
  assign out_ch.temp_word    = out_temp_word_r;
  assign out_ch.hum_word     = out_hum_word_r;
  assign out_ch.temp_centi   = out_temp_centi_r;
  assign out_ch.hum_centi    = out_hum_centi_r;

`ifndef SYNTHESIS
  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_emits) |=> out_valid_r)
    else $error("sixth byte did not load a result");

  a_emit_realigns: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_emits) |=> (pos_r == POS_TEMP_HI) && (crc_r == CRC_INIT))
    else $error("frame state not restarted after sixth byte");

  a_good_words_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_fire && s1_emits && (status_nxt == ST_GOOD)) |=>
      ($stable(good_temp_r) && $stable(good_hum_r)))
    else $error("good words changed without a good frame");

  a_stall_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_emits && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked result");
`endif

endmodule
